[src/ntlv_pkg.sv]
// ----------------------------------------------------------------------------
// ntlv_pkg
// Shared types and constants of the notification attribute TLV parser.
// ----------------------------------------------------------------------------
package ntlv_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned NumSlots   = 4;
  localparam int unsigned SlotW      = 2;
  localparam int unsigned CfgIdxW    = 3;

  // header byte positions
  localparam logic [2:0] PosEvent    = 3'd1;
  localparam logic [2:0] PosUuid0    = 3'd2;
  localparam logic [2:0] PosUuid1    = 3'd3;
  localparam logic [2:0] PosUuid2    = 3'd4;
  localparam logic [2:0] PosUuid3    = 3'd5;
  localparam logic [2:0] HeaderLen   = 3'd6;
  localparam logic [7:0] MaxEventId  = 8'd2;

  typedef enum logic [1:0] {
    PhId    = 2'd0,
    PhLenLo = 2'd1,
    PhLenHi = 2'd2,
    PhData  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KindHeader = 2'd0,
    KindData   = 2'd1,
    KindEnd    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StShort    = 2'd1,
    StBadEvent = 2'd2,
    StTrunc    = 2'd3
  } status_e;

  typedef struct packed {
    logic               valid;
    logic [CfgIdxW-1:0] index;
    logic [7:0]         data;
  } cfg_wr_t;

  // one accepted byte's worth of results: a header or data item, and/or an end
  typedef struct packed {
    logic             prim_hdr;
    logic             prim_data;
    logic             has_end;
    logic [1:0]       event_id;
    logic [31:0]      uuid;
    logic [SlotW-1:0] slot;
    logic [7:0]       data_byte;
    logic             attr_first;
    logic             attr_last;
    status_e          status;
  } rec_t;

  typedef struct packed {
    kind_e            kind;
    logic [1:0]       event_id;
    logic [31:0]      uuid;
    logic [SlotW-1:0] slot;
    logic [7:0]       data_byte;
    logic             attr_first;
    logic             attr_last;
    status_e          status;
    logic             last;
  } res_t;

endpackage

[src/notification_attribute_tlv_parser.sv]
// ----------------------------------------------------------------------------
// notification_attribute_tlv_parser
// Parses notification header and TLV attributes, streams selected data bytes.
// ----------------------------------------------------------------------------
// Takes one byte per cycle on push/full. The parser updates its state in the
// cycle a byte is accepted and writes at most one record into a QueueDepth
// entry queue; the result stage drains one result per cycle unless pop stalls
// it, so a byte that is both the final header byte and the packet end yields
// two results. Results go through the queue and the output register. full
// rises only when the queue is full because the consumer stalls on pop. The
// four attribute id registers are written through cfg_valid_i/cfg_ready_o and
// are always ready; indexes beyond the last register are ignored.
module notification_attribute_tlv_parser #(
  parameter int unsigned QueueDepth = ntlv_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ntlv_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                    cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    in_byte_i,
  input  logic                          pkt_last_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    kind_o,
  output logic [1:0]                    event_id_o,
  output logic [31:0]                   uuid_o,
  output logic [ntlv_pkg::SlotW-1:0]    slot_o,
  output logic [7:0]                    data_byte_o,
  output logic                          attr_first_o,
  output logic                          attr_last_o,
  output logic [1:0]                    status_o,
  output logic                          last_o
);

  ntlv_pkg::cfg_wr_t cfg_wr;
  ntlv_pkg::rec_t    fr_rec, q_rec;
  ntlv_pkg::res_t    res;
  logic              accept, fr_valid, q_full, q_empty, q_pop;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  assign full   = q_full;
  assign accept = push && !q_full;

  ntlv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_wr),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .pkt_last_i  (pkt_last_i),
    .rec_valid_o (fr_valid),
    .rec_o       (fr_rec)
  );

  ntlv_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .wdata_i (fr_rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rec),
    .empty_o (q_empty)
  );

  ntlv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (!q_empty),
    .rec_i       (q_rec),
    .rec_pop_o   (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign kind_o       = res.kind;
  assign event_id_o   = res.event_id;
  assign uuid_o       = res.uuid;
  assign slot_o       = res.slot;
  assign data_byte_o  = res.data_byte;
  assign attr_first_o = res.attr_first;
  assign attr_last_o  = res.attr_last;
  assign status_o     = res.status;
  assign last_o       = res.last;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fr_valid |-> !q_full)
    else $error("record written into full queue");

  a_last_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (last_o == (kind_o == ntlv_pkg::KindEnd)))
    else $error("last flag does not match end result");

  a_header_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == ntlv_pkg::KindHeader) |->
      (data_byte_o == 8'd0 && slot_o == '0 && !attr_first_o && !attr_last_o))
    else $error("header result carries data fields");

endmodule

[src/ntlv_front.sv]
// ----------------------------------------------------------------------------
// ntlv_front
// Byte parser: header capture, TLV walk, slot match, end status.
// ----------------------------------------------------------------------------
module ntlv_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ntlv_pkg::cfg_wr_t cfg_i,
  input  logic             accept_i,
  input  logic [7:0]       in_byte_i,
  input  logic             pkt_last_i,
  output logic             rec_valid_o,
  output ntlv_pkg::rec_t   rec_o
);

  logic [7:0]                   cfg_ids_q [ntlv_pkg::NumSlots];
  logic [2:0]                   pos_q, pos_d;
  ntlv_pkg::phase_e             phase_q, phase_d;
  logic                         matched_q, matched_d;
  logic [ntlv_pkg::SlotW-1:0]   slot_q, slot_d;
  logic [15:0]                  rem_q, rem_d;
  logic [1:0]                   event_q, event_d;
  logic [31:0]                  uuid_q, uuid_d;
  logic                         bad_q, bad_d;
  logic                         first_q, first_d;
  logic                         id_hit;
  logic [ntlv_pkg::SlotW-1:0]   id_slot;
  ntlv_pkg::rec_t               rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < int'(ntlv_pkg::NumSlots); s++) begin
        cfg_ids_q[s] <= 8'(s);
      end
    end else if (cfg_i.valid && cfg_i.index < ntlv_pkg::CfgIdxW'(ntlv_pkg::NumSlots)) begin
      cfg_ids_q[cfg_i.index[ntlv_pkg::SlotW-1:0]] <= cfg_i.data;
    end
  end

  // lowest slot wins when several ids are equal
  always_comb begin
    id_hit  = 1'b0;
    id_slot = '0;
    for (int s = int'(ntlv_pkg::NumSlots) - 1; s >= 0; s--) begin
      if (cfg_ids_q[s] == in_byte_i) begin
        id_hit  = 1'b1;
        id_slot = ntlv_pkg::SlotW'(s);
      end
    end
  end

  always_comb begin
    pos_d     = pos_q;
    phase_d   = phase_q;
    matched_d = matched_q;
    slot_d    = slot_q;
    rem_d     = rem_q;
    event_d   = event_q;
    uuid_d    = uuid_q;
    bad_d     = bad_q;
    first_d   = first_q;
    rec       = '0;
    rec.status = ntlv_pkg::StOk;

    if (pos_q < ntlv_pkg::HeaderLen) begin
      case (pos_q)
        ntlv_pkg::PosEvent: begin
          event_d = in_byte_i[1:0];
          bad_d   = in_byte_i > ntlv_pkg::MaxEventId;
        end
        ntlv_pkg::PosUuid0: uuid_d[7:0]   = uuid_q[7:0]   | in_byte_i;
        ntlv_pkg::PosUuid1: uuid_d[15:8]  = uuid_q[15:8]  | in_byte_i;
        ntlv_pkg::PosUuid2: uuid_d[23:16] = uuid_q[23:16] | in_byte_i;
        ntlv_pkg::PosUuid3: uuid_d[31:24] = uuid_q[31:24] | in_byte_i;
        default: ;
      endcase
      if (pos_q == ntlv_pkg::PosUuid3 && !bad_q) begin
        rec.prim_hdr = 1'b1;
        rec.event_id = event_q;
        rec.uuid     = uuid_d;
      end
      pos_d = pos_q + 3'd1;
    end else if (!bad_q) begin
      case (phase_q)
        ntlv_pkg::PhId: begin
          matched_d = id_hit;
          slot_d    = id_slot;
          phase_d   = ntlv_pkg::PhLenLo;
        end
        ntlv_pkg::PhLenLo: begin
          rem_d   = {8'h00, in_byte_i};
          phase_d = ntlv_pkg::PhLenHi;
        end
        ntlv_pkg::PhLenHi: begin
          rem_d = {in_byte_i, rem_q[7:0]};
          if (rem_d == 16'd0) begin
            phase_d = ntlv_pkg::PhId;
          end else begin
            first_d = 1'b1;
            phase_d = ntlv_pkg::PhData;
          end
        end
        default: begin
          rem_d = rem_q - 16'd1;
          if (matched_q) begin
            rec.prim_data  = 1'b1;
            rec.slot       = slot_q;
            rec.data_byte  = in_byte_i;
            rec.attr_first = first_q;
            rec.attr_last  = rem_d == 16'd0;
          end
          first_d = 1'b0;
          if (rem_d == 16'd0) phase_d = ntlv_pkg::PhId;
        end
      endcase
    end

    if (pkt_last_i) begin
      rec.has_end = 1'b1;
      if (pos_d < ntlv_pkg::HeaderLen) begin
        rec.status = ntlv_pkg::StShort;
      end else if (bad_d) begin
        rec.status = ntlv_pkg::StBadEvent;
      end else if (phase_d == ntlv_pkg::PhLenLo ||
                   (phase_d == ntlv_pkg::PhData && rem_d != 16'd0)) begin
        rec.status = ntlv_pkg::StTrunc;
      end else begin
        rec.status = ntlv_pkg::StOk;
      end
      pos_d     = '0;
      phase_d   = ntlv_pkg::PhId;
      matched_d = 1'b0;
      slot_d    = '0;
      rem_d     = '0;
      event_d   = '0;
      uuid_d    = '0;
      bad_d     = 1'b0;
      first_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      phase_q   <= ntlv_pkg::PhId;
      matched_q <= 1'b0;
      slot_q    <= '0;
      rem_q     <= '0;
      event_q   <= '0;
      uuid_q    <= '0;
      bad_q     <= 1'b0;
      first_q   <= 1'b0;
    end else if (accept_i) begin
      pos_q     <= pos_d;
      phase_q   <= phase_d;
      matched_q <= matched_d;
      slot_q    <= slot_d;
      rem_q     <= rem_d;
      event_q   <= event_d;
      uuid_q    <= uuid_d;
      bad_q     <= bad_d;
      first_q   <= first_d;
    end
  end

  assign rec_o       = rec;
  assign rec_valid_o = accept_i && (rec.prim_hdr || rec.prim_data || rec.has_end);

endmodule

[src/ntlv_fifo.sv]
// ----------------------------------------------------------------------------
// ntlv_fifo
// Short record queue between the parser and the result stage.
// ----------------------------------------------------------------------------
module ntlv_fifo #(
  parameter int unsigned Depth = ntlv_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ntlv_pkg::rec_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output ntlv_pkg::rec_t rdata_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  ntlv_pkg::rec_t  mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      if (do_pop)  rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: ;
      endcase
    end
  end

endmodule

[src/ntlv_back.sv]
// ----------------------------------------------------------------------------
// ntlv_back
// Result stage: expands a record into one or two results, output register.
// ----------------------------------------------------------------------------
module ntlv_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rec_valid_i,
  input  ntlv_pkg::rec_t rec_i,
  output logic           rec_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output ntlv_pkg::res_t res_o
);

  ntlv_pkg::res_t res_q, res_d;
  logic           valid_q, valid_d;
  logic           second_q, second_d;
  logic           load;
  ntlv_pkg::res_t prim_res, end_res;

  always_comb begin
    prim_res        = '0;
    prim_res.status = ntlv_pkg::StOk;
    if (rec_i.prim_hdr) begin
      prim_res.kind     = ntlv_pkg::KindHeader;
      prim_res.event_id = rec_i.event_id;
      prim_res.uuid     = rec_i.uuid;
    end else begin
      prim_res.kind       = ntlv_pkg::KindData;
      prim_res.slot       = rec_i.slot;
      prim_res.data_byte  = rec_i.data_byte;
      prim_res.attr_first = rec_i.attr_first;
      prim_res.attr_last  = rec_i.attr_last;
    end
    end_res        = '0;
    end_res.kind   = ntlv_pkg::KindEnd;
    end_res.status = rec_i.status;
    end_res.last   = 1'b1;
  end

  assign load = !valid_q || pop_i;

  // second_q: primary result of the head record already sent, end still due
  always_comb begin
    res_d     = res_q;
    valid_d   = valid_q;
    second_d  = second_q;
    rec_pop_o = 1'b0;
    if (load) begin
      if (rec_valid_i) begin
        valid_d = 1'b1;
        if ((rec_i.prim_hdr || rec_i.prim_data) && !second_q) begin
          res_d = prim_res;
          if (rec_i.has_end) begin
            second_d = 1'b1;
          end else begin
            rec_pop_o = 1'b1;
          end
        end else begin
          res_d     = end_res;
          rec_pop_o = 1'b1;
          second_d  = 1'b0;
        end
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      second_q <= second_d;
    end
  end

  assign empty_o = !valid_q;
  assign res_o   = res_q;

endmodule
